[sv/rmth_pkg.sv]
package rmth_pkg;

    localparam int unsigned CAPACITY_DEF     = 1024;
    localparam int unsigned SAMPLE_WIDTH_DEF = 32;
    localparam int unsigned DATA_W           = 32;
    localparam int unsigned COUNT_W          = 11;

    // Command from the sequencer to a heap engine
    typedef enum logic [1:0] {
        HOP_NONE,
        HOP_PUSH,
        HOP_REPLACE
    } heap_op_t;

    // Status returned by a heap engine
    typedef struct packed {
        logic busy;
        logic done;
    } heap_stat_t;

endpackage

[sv/rmth_heap.sv]
// One binary heap in a single-port synchronous memory, with a top-of-heap register.
// Push sifts up from the tail, replace sifts down from the root.
module rmth_heap
    import rmth_pkg::*;
#(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned WIDTH = 32,
    parameter bit          IS_MAX = 1'b1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  heap_op_t                 op,
    input  logic signed [WIDTH-1:0]  value,
    input  logic [$clog2(DEPTH+1)-1:0] size,
    output logic signed [WIDTH-1:0]  top,
    output heap_stat_t               stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW = $clog2(DEPTH+1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } state_t;

    logic signed [WIDTH-1:0] mem [DEPTH];

    state_t                  state_reg;
    logic [AW-1:0]           idx_reg;
    logic signed [WIDTH-1:0] val_reg;
    logic signed [WIDTH-1:0] top_reg;
    logic signed [WIDTH-1:0] lval_reg;
    logic [SW-1:0]           size_reg;
    logic                    has_r_reg;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [WIDTH-1:0] wdata;
    logic [AW-1:0]           raddr;
    logic signed [WIDTH-1:0] rdata;
    logic [AW-1:0]           parent;
    logic [SW:0]             lchild;
    logic                    l_ok;
    logic                    r_ok;
    logic                    up_win;
    logic                    l_win;
    logic                    r_win_l;
    logic                    r_win_v;

    // "a above b" in heap order
    function automatic logic above(input logic signed [WIDTH-1:0] a,
                                   input logic signed [WIDTH-1:0] b);
        above = IS_MAX ? (a > b) : (b > a);
    endfunction

    assign parent  = AW'((idx_reg - AW'(1)) >> 1);
    assign lchild  = (SW+1)'({idx_reg, 1'b1});
    assign l_ok    = (lchild < (SW+1)'(size_reg));
    assign r_ok    = ((lchild + (SW+1)'(1)) < (SW+1)'(size_reg));
    assign up_win  = above(val_reg, rdata);
    assign l_win   = above(lval_reg, val_reg);
    assign r_win_l = above(rdata, lval_reg);
    assign r_win_v = above(rdata, val_reg);

    // Memory port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    // Read address and write control
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = val_reg;
        raddr = idx_reg;
        unique case (state_reg)
            S_UP_RD:  raddr = parent;
            S_DN_RDL: raddr = AW'(lchild);
            S_DN_RDR: raddr = AW'(lchild + (SW+1)'(1));
            S_UP_CMP:
            begin
                we = 1'b1;
                if (idx_reg != '0 && up_win)
                begin
                    wdata = rdata;
                end
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if (has_r_reg && r_win_l && r_win_v)
                begin
                    wdata = rdata;
                end
                else if (l_win)
                begin
                    wdata = lval_reg;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            val_reg   <= '0;
            lval_reg  <= '0;
            top_reg   <= '0;
            has_r_reg <= 1'b0;
            size_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (op == HOP_PUSH)
                    begin
                        val_reg   <= value;
                        idx_reg   <= AW'(size);
                        size_reg  <= size + SW'(1);
                        if (size == '0)
                        begin
                            top_reg <= value;
                        end
                        state_reg <= S_UP_RD;
                    end
                    else if (op == HOP_REPLACE)
                    begin
                        val_reg   <= value;
                        idx_reg   <= '0;
                        size_reg  <= size;
                        state_reg <= S_DN_RDL;
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (idx_reg != '0 && up_win)
                    begin
                        idx_reg   <= parent;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        if (idx_reg == '0)
                        begin
                            top_reg <= val_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DN_RDL:
                begin
                    if (idx_reg == '0)
                    begin
                        top_reg <= val_reg;
                    end
                    if (!l_ok)
                    begin
                        state_reg <= S_DN_CMP;
                        has_r_reg <= 1'b0;
                        lval_reg  <= val_reg;
                    end
                    else
                    begin
                        has_r_reg <= r_ok;
                        state_reg <= S_DN_RDR;
                    end
                end
                S_DN_RDR:
                begin
                    lval_reg  <= rdata;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    // rdata holds right child if present, lval_reg the left one
                    if (!l_ok)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (has_r_reg && r_win_l && r_win_v)
                    begin
                        if (idx_reg == '0)
                        begin
                            top_reg <= rdata;
                        end
                        idx_reg   <= AW'(lchild + (SW+1)'(1));
                        state_reg <= S_DN_RDL;
                    end
                    else if (above(lval_reg, val_reg))
                    begin
                        if (idx_reg == '0)
                        begin
                            top_reg <= lval_reg;
                        end
                        idx_reg   <= AW'(lchild);
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign top       = top_reg;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);

endmodule

[sv/rmth_ctrl.sv]
// Per-item sequencer: classifies the sample, issues heap commands, forms the result.
module rmth_ctrl
    import rmth_pkg::*;
#(
    parameter int unsigned CAPACITY     = CAPACITY_DEF,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int unsigned LSW          = 10,
    parameter int unsigned USW          = 10
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] median_value,
    output logic [COUNT_W-1:0]       sample_count,
    output logic                     overflow,
    output heap_op_t                 lo_op,
    output heap_op_t                 up_op,
    output logic signed [SAMPLE_WIDTH-1:0] lo_val,
    output logic signed [SAMPLE_WIDTH-1:0] up_val,
    output logic [LSW-1:0]           lo_size,
    output logic [USW-1:0]           up_size,
    input  logic signed [SAMPLE_WIDTH-1:0] lo_top,
    input  logic signed [SAMPLE_WIDTH-1:0] up_top,
    input  heap_stat_t               lo_stat,
    input  heap_stat_t               up_stat
);

    localparam int unsigned TW = $clog2(CAPACITY+1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_FIRST,
        C_SECOND,
        C_RESULT
    } cstate_t;

    cstate_t                       state_reg;
    logic signed [SAMPLE_WIDTH-1:0] v_reg;
    logic signed [SAMPLE_WIDTH-1:0] med_reg;
    logic [LSW-1:0]                 lsize_reg;
    logic [USW-1:0]                 usize_reg;
    logic                           ovf_reg;
    logic                           second_lo_reg;
    logic                           second_up_reg;
    logic signed [SAMPLE_WIDTH-1:0] second_val_reg;
    logic                           out_valid_reg;
    logic signed [DATA_W-1:0]       med_out_reg;
    logic [COUNT_W-1:0]             cnt_out_reg;
    logic                           ovf_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] v_in;
    logic [TW:0]                    total;
    logic                           heaps_idle;
    logic                           cmd_valid;
    logic                           result_load;
    heap_op_t                       lo_cmd;
    heap_op_t                       up_cmd;
    logic signed [SAMPLE_WIDTH-1:0] lo_cmd_val;
    logic signed [SAMPLE_WIDTH-1:0] up_cmd_val;

    assign v_in        = SAMPLE_WIDTH'(sample);
    assign total       = (TW+1)'(lsize_reg) + (TW+1)'(usize_reg);
    assign heaps_idle  = !lo_stat.busy && !up_stat.busy;
    // a waiting result only holds the next item in C_RESULT
    assign in_stall    = (state_reg != C_IDLE);
    assign result_load = (state_reg == C_RESULT) && heaps_idle && !(out_valid_reg && out_stall);

    // First command for the held sample
    always_comb
    begin
        lo_cmd     = HOP_NONE;
        up_cmd     = HOP_NONE;
        lo_cmd_val = v_reg;
        up_cmd_val = v_reg;
        if (v_reg > med_reg)
        begin
            if ((TW+1)'(usize_reg) == (TW+1)'(lsize_reg))
            begin
                if (usize_reg == '0 || !(v_reg > up_top))
                begin
                    lo_cmd = HOP_PUSH;
                end
                else
                begin
                    up_cmd = HOP_REPLACE;
                end
            end
            else
            begin
                up_cmd = HOP_PUSH;
            end
        end
        else
        begin
            if ((TW+1)'(lsize_reg) == (TW+1)'(usize_reg) + (TW+1)'(1))
            begin
                if (!(lo_top > v_reg))
                begin
                    up_cmd = HOP_PUSH;
                end
                else
                begin
                    lo_cmd = HOP_REPLACE;
                end
            end
            else
            begin
                lo_cmd = HOP_PUSH;
            end
        end
    end

    assign cmd_valid = (state_reg == C_FIRST) && heaps_idle && !ovf_reg;
    assign lo_op   = (state_reg == C_SECOND && heaps_idle && second_lo_reg) ? HOP_PUSH :
                     (cmd_valid ? lo_cmd : HOP_NONE);
    assign up_op   = (state_reg == C_SECOND && heaps_idle && second_up_reg) ? HOP_PUSH :
                     (cmd_valid ? up_cmd : HOP_NONE);
    assign lo_val  = (state_reg == C_SECOND) ? second_val_reg : lo_cmd_val;
    assign up_val  = (state_reg == C_SECOND) ? second_val_reg : up_cmd_val;
    assign lo_size = lsize_reg;
    assign up_size = usize_reg;

    // Item sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= C_IDLE;
            v_reg          <= '0;
            med_reg        <= '0;
            lsize_reg      <= '0;
            usize_reg      <= '0;
            ovf_reg        <= 1'b0;
            second_lo_reg  <= 1'b0;
            second_up_reg  <= 1'b0;
            second_val_reg <= '0;
            out_valid_reg  <= 1'b0;
            med_out_reg    <= '0;
            cnt_out_reg    <= '0;
            ovf_out_reg    <= 1'b0;
        end
        else
        begin
            // result valid: set on load, cleared on transfer
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                C_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        v_reg     <= v_in;
                        ovf_reg   <= (total >= (TW+1)'(CAPACITY));
                        state_reg <= C_FIRST;
                    end
                end
                C_FIRST:
                begin
                    if (ovf_reg)
                    begin
                        state_reg <= C_RESULT;
                    end
                    else if (heaps_idle)
                    begin
                        if (lo_cmd == HOP_PUSH)
                        begin
                            lsize_reg <= lsize_reg + LSW'(1);
                        end
                        if (up_cmd == HOP_PUSH)
                        begin
                            usize_reg <= usize_reg + USW'(1);
                        end
                        // a replaced top moves to the other half next
                        second_lo_reg  <= (up_cmd == HOP_REPLACE);
                        second_up_reg  <= (lo_cmd == HOP_REPLACE);
                        second_val_reg <= (up_cmd == HOP_REPLACE) ? up_top : lo_top;
                        state_reg      <= C_SECOND;
                    end
                end
                C_SECOND:
                begin
                    if (heaps_idle)
                    begin
                        if (second_lo_reg)
                        begin
                            lsize_reg <= lsize_reg + LSW'(1);
                        end
                        if (second_up_reg)
                        begin
                            usize_reg <= usize_reg + USW'(1);
                        end
                        second_lo_reg <= 1'b0;
                        second_up_reg <= 1'b0;
                        if (!second_lo_reg && !second_up_reg)
                        begin
                            state_reg <= C_RESULT;
                        end
                    end
                end
                C_RESULT:
                begin
                    if (result_load)
                    begin
                        if (!ovf_reg)
                        begin
                            med_reg     <= lo_top;
                            med_out_reg <= DATA_W'(lo_top);
                        end
                        else
                        begin
                            med_out_reg <= DATA_W'(med_reg);
                        end
                        cnt_out_reg <= COUNT_W'(total);
                        ovf_out_reg <= ovf_reg;
                        state_reg   <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_value = med_out_reg;
    assign sample_count = cnt_out_reg;
    assign overflow     = ovf_out_reg;

endmodule

[sv/running_median_two_heaps_unit.sv]
// Channel | Signals                                   | Transfer when
// in      | in_valid, in_stall, sample                | in_valid && !in_stall
// out     | out_valid, out_stall, median_value,       | out_valid && !out_stall
//         | sample_count, overflow                    |
// One item at a time: classify, one or two heap operations, then load the result.
// The slowest item is a replace that sifts down one heap, then a push that sifts up the other;
// the next item is taken once the result is loaded. Overflowed items skip the heap operations.
// Reset clears sizes and last median; heap memories need no clearing.
// A stalled result holds the unit out of the next transfer's last step only.
module running_median_two_heaps_unit
    import rmth_pkg::*;
#(
    parameter int unsigned CAPACITY     = CAPACITY_DEF,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] median_value,
    output logic [COUNT_W-1:0]       sample_count,
    output logic                     overflow
);

    localparam int unsigned LDEPTH = (CAPACITY + 1) / 2;
    localparam int unsigned UDEPTH = CAPACITY / 2;
    localparam int unsigned LSW    = $clog2(LDEPTH + 1);
    localparam int unsigned USW    = $clog2(UDEPTH + 1);

    heap_op_t                       lo_op;
    heap_op_t                       up_op;
    logic signed [SAMPLE_WIDTH-1:0] lo_val;
    logic signed [SAMPLE_WIDTH-1:0] up_val;
    logic [LSW-1:0]                 lo_size;
    logic [USW-1:0]                 up_size;
    logic signed [SAMPLE_WIDTH-1:0] lo_top;
    logic signed [SAMPLE_WIDTH-1:0] up_top;
    heap_stat_t                     lo_stat;
    heap_stat_t                     up_stat;

    rmth_ctrl #(
        .CAPACITY     (CAPACITY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LSW          (LSW),
        .USW          (USW)
    ) u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .sample,
        .out_valid, .out_stall, .median_value, .sample_count, .overflow,
        .lo_op, .up_op, .lo_val, .up_val, .lo_size, .up_size,
        .lo_top, .up_top, .lo_stat, .up_stat
    );

    // Lower half: max-heap
    rmth_heap #(
        .DEPTH  (LDEPTH),
        .WIDTH  (SAMPLE_WIDTH),
        .IS_MAX (1'b1)
    ) u_lower (
        .clk, .rst_n, .op(lo_op), .value(lo_val), .size(lo_size),
        .top(lo_top), .stat(lo_stat)
    );

    // Upper half: min-heap
    rmth_heap #(
        .DEPTH  (UDEPTH),
        .WIDTH  (SAMPLE_WIDTH),
        .IS_MAX (1'b0)
    ) u_upper (
        .clk, .rst_n, .op(up_op), .value(up_val), .size(up_size),
        .top(up_top), .stat(up_stat)
    );

endmodule

[sv/rmth_checker.sv]
module rmth_checker
    import rmth_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] median_value,
    input logic [COUNT_W-1:0] sample_count,
    input logic              overflow
);

    // Output holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_value))
        else $error("result changed under stall");

    // A transfer in is followed by no new result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid || $past(out_valid))
        else $error("result too early");

    // Overflow never with a count of zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> sample_count != '0)
        else $error("overflow with empty store");

    // Busy after accepting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

endmodule

bind running_median_two_heaps_unit rmth_checker u_rmth_checker (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .median_value, .sample_count, .overflow
);

[tb/running_median_checker.sv]
module running_median_checker
    import rmth_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] median_value,
    input  logic [COUNT_W-1:0]       sample_count,
    input  logic                     overflow,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic signed [DATA_W-1:0] median;
        logic [COUNT_W-1:0]       count;
        logic                     ovf;
    } median_result_t;

    // every sample held so far, kept in ascending order
    logic signed [DATA_W-1:0] held_sorted[$];
    logic signed [DATA_W-1:0] last_median;
    median_result_t           median_q[$];

    // insert the sample into the sorted store, unless it is full, and derive the lower median
    function automatic median_result_t predict_median(input logic signed [DATA_W-1:0] v);
        median_result_t r;
        int             pos;
        pos = 0;
        if (held_sorted.size() >= CAPACITY)
        begin
            r.ovf = 1'b1;
        end
        else
        begin
            r.ovf = 1'b0;
            while (pos < held_sorted.size() && held_sorted[pos] <= v)
                pos++;
            held_sorted.insert(pos, v);
            last_median = held_sorted[(held_sorted.size() - 1) / 2];
        end
        r.median = last_median;
        r.count  = COUNT_W'(held_sorted.size());
        return r;
    endfunction

    assign pending = median_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        median_result_t want;
        if (!rst_n)
        begin
            held_sorted.delete();
            median_q.delete();
            last_median = '0;
            fail_count  = 0;
        end
        else
        begin
            // input transfer: predict, queued at the tail
            if (in_valid && !in_stall)
                median_q.insert(median_q.size(), predict_median(sample));
            // output transfer: compare against oldest prediction
            if (out_valid && !out_stall)
            begin
                if (median_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: median %0d count %0d ovf %0b",
                                 median_value, sample_count, overflow);
                end
                else
                begin
                    want = median_q.pop_front();
                    if (want.median !== median_value || want.count !== sample_count ||
                        want.ovf !== overflow)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp median %0d count %0d ovf %0b, got %0d %0d %0b",
                                     want.median, want.count, want.ovf,
                                     median_value, sample_count, overflow);
                    end
                end
            end
        end
    end

endmodule

[tb/running_median_two_heaps_unit_tb.sv]
module running_median_two_heaps_unit_tb;
    import rmth_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] median_value;
    logic [COUNT_W-1:0]       sample_count;
    logic                     overflow;
    int                       fail_count;
    int                       pending;

    int   idle_pct;
    int   stall_pct;
    logic long_hold;

    running_median_two_heaps_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_value (median_value),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    running_median_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_value (median_value),
        .sample_count (sample_count),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8000000;
        $display("running_median_two_heaps_unit_tb failed");
        $finish;
    end

    // receiver: random stalls plus the long hold-off
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            out_stall <= long_hold || ($urandom_range(99) < stall_pct);
        end
    end

    // offer one sample; valid stays high across back-to-back transfers
    task automatic send_sample(input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic signed [DATA_W-1:0] random_sample();
        case ($urandom_range(5))
            0:       return $urandom_range(40) - 20;
            1:       return $urandom_range(3) < 2 ? 32'sh7fffffff : 32'sh80000000;
            2:       return $urandom_range(1000) - 500;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic signed [DATA_W-1:0] directed[$];
        int                       phase;
        in_valid  = 1'b0;
        sample    = '0;
        idle_pct  = 0;
        stall_pct = 0;
        long_hold = 1'b0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sample, extremes, ties with the median, alternating bits
        directed = '{32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd0,
                     32'sd0, 32'sd5, 32'sd5, -32'sd5, 32'sh55555555, 32'shaaaaaaaa,
                     32'sh7fffffff, 32'sh80000000, 32'sd1, 32'sd1, -32'sd1, 32'sd2};
        foreach (directed[i])
            send_sample(directed[i]);

        // long receiver hold-off while samples keep coming
        long_hold <= 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                long_hold <= 1'b0;
            end
            repeat (40) send_sample(random_sample());
        join

        // random phases: none, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1) ? 71 : (phase == 3) ? 36 : 0;
            stall_pct = (phase == 2) ? 71 : (phase == 3) ? 36 : 0;
            repeat (478) send_sample(random_sample());
        end
        in_valid <= 1'b0;

        // drain
        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("running_median_two_heaps_unit_tb passed");
        else
            $display("running_median_two_heaps_unit_tb failed");
        $finish;
    end

endmodule
